// ===== design/nnro_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order: shared definitions
// Default sizes and the mode codes of the shared metric unit.
// ----------------------------------------------------------------------------
package nnro_pkg;

  localparam int NNRO_MAX_POINTS = 16;
  localparam int NNRO_COORD_BITS = 8;

  // Metric unit modes.
  localparam logic MODE_SUM  = 1'b0;  // x + y of the point itself
  localparam logic MODE_DIST = 1'b1;  // squared distance to the reference point

endpackage

// ===== design/nnro_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order: point input channel
// Valid/ready channel carrying one camera point and its end-of-set flag.
// ----------------------------------------------------------------------------
interface nnro_in_if
  import nnro_pkg::*;
#(
  parameter int W = NNRO_COORD_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic         last;

  modport source (output valid, x, y, last, input ready);
  modport sink   (input valid, x, y, last, output ready);
endinterface

// ===== design/nnro_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order: route output channel
// Valid/ready channel carrying one ordered point and its end-of-route flag.
// ----------------------------------------------------------------------------
interface nnro_out_if
  import nnro_pkg::*;
#(
  parameter int W = NNRO_COORD_BITS
);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_x;
  logic [W-1:0] out_y;
  logic         out_last;

  modport source (output valid, out_x, out_y, out_last, input ready);
  modport sink   (input valid, out_x, out_y, out_last, output ready);
endinterface

// ===== design/nnro_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nnro_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/nnro_metric.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order: shared metric unit
// Two-stage pipeline giving either x+y or the squared distance to a
// reference point; index and point travel alongside the value.
// ----------------------------------------------------------------------------
module nnro_metric
  import nnro_pkg::*;
#(
  parameter int COORD_BITS = NNRO_COORD_BITS,
  parameter int IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] ref_x,
  input  logic [COORD_BITS-1:0] ref_y,
  input  logic                  in_valid,
  input  logic [IDX_W-1:0]      in_idx,
  input  logic [COORD_BITS-1:0] in_x,
  input  logic [COORD_BITS-1:0] in_y,
  output logic                  out_valid,
  output logic [IDX_W-1:0]      out_idx,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [2*COORD_BITS:0] out_value
);

  logic [COORD_BITS-1:0]   dx;
  logic [COORD_BITS-1:0]   dy;
  logic [2*COORD_BITS-1:0] term_a_next;
  logic [2*COORD_BITS-1:0] term_b_next;

  logic                    s1_valid;
  logic [IDX_W-1:0]        s1_idx;
  logic [COORD_BITS-1:0]   s1_x;
  logic [COORD_BITS-1:0]   s1_y;
  logic [2*COORD_BITS-1:0] term_a;
  logic [2*COORD_BITS-1:0] term_b;

  always_comb begin
    dx = (in_x > ref_x) ? (in_x - ref_x) : (ref_x - in_x);
    dy = (in_y > ref_y) ? (in_y - ref_y) : (ref_y - in_y);
    if (mode == MODE_DIST) begin
      term_a_next = dx * dx;
      term_b_next = dy * dy;
    end else begin
      term_a_next = {{COORD_BITS{1'b0}}, in_x};
      term_b_next = {{COORD_BITS{1'b0}}, in_y};
    end
  end

  // Stage 1: squares (or raw coordinates); stage 2: the sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
    s1_idx    <= in_idx;
    s1_x      <= in_x;
    s1_y      <= in_y;
    term_a    <= term_a_next;
    term_b    <= term_b_next;
    out_idx   <= s1_idx;
    out_x     <= s1_x;
    out_y     <= s1_y;
    out_value <= {1'b0, term_a} + {1'b0, term_b};
  end

endmodule

// ===== design/nearest_neighbor_route_order.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order
// Collects camera points and emits them in greedy nearest-neighbor order.
// ----------------------------------------------------------------------------
// Points arrive one per transaction on the points channel and are taken one
// per cycle while the block is loading; up to MAX_POINTS are kept and any
// point beyond that is dropped. The transaction flagged last closes the set
// (it is stored too, if there is room). The block then drops ready and orders
// the set in place: the point with the smallest x+y moves to position 0, the
// earliest one winning ties, and then for each position i the nearest of the
// remaining points (squared Euclidean distance, earliest in current order
// winning ties) moves to position i+1. Every step is a scan through the point
// RAM, one read a cycle, into a single two-stage metric unit, followed by a
// swap: SWAP_A writes the chosen point to the position and SWAP_B writes
// the displaced point to where the chosen one was. The ordered points then
// leave on the route channel one transaction at a time, each read from the
// RAM and registered before it is offered, with out_last on the final one;
// after that handshake the block starts a new set.
// ----------------------------------------------------------------------------
module nearest_neighbor_route_order
  import nnro_pkg::*;
#(
  parameter int MAX_POINTS = NNRO_MAX_POINTS,
  parameter int COORD_BITS = NNRO_COORD_BITS
) (
  input logic       clk,
  input logic       rst,
  nnro_in_if.sink   points,
  nnro_out_if.source route
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PT_W  = 2 * COORD_BITS;
  localparam int VAL_W = 2 * COORD_BITS + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  localparam logic [2:0] ST_LOAD      = 3'd0;
  localparam logic [2:0] ST_SCAN      = 3'd1;
  localparam logic [2:0] ST_SWAP_A    = 3'd2;
  localparam logic [2:0] ST_SWAP_B    = 3'd3;
  localparam logic [2:0] ST_EMIT_RD   = 3'd4;
  localparam logic [2:0] ST_EMIT_LD   = 3'd5;
  localparam logic [2:0] ST_EMIT_WAIT = 3'd6;

  logic [2:0]       state;
  logic [CNT_W-1:0] count;      // points held in the current set
  logic [CNT_W-1:0] start;      // position being filled by the current scan
  logic [CNT_W-1:0] issue_j;    // next RAM index read by the scan
  logic [CNT_W-1:0] k;          // emit position
  logic             seed;       // scan is the x+y seed pass
  logic [PT_W-1:0]  cur;        // point at the last filled position
  logic [PT_W-1:0]  best_pt;
  logic [PT_W-1:0]  first_pt;   // point originally at the filled position
  logic [IDX_W-1:0] best_idx;
  logic [VAL_W-1:0] best_val;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic             out_v;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;
  logic             out_last_r;

  logic             in_acc;
  logic             out_acc;
  logic             store_ok;
  logic             issue;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [PT_W-1:0]  wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [PT_W-1:0]  rd_data;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] start_inc;
  logic [CNT_W-1:0] last_pos;

  logic                  m_valid;
  logic [IDX_W-1:0]      m_idx;
  logic [COORD_BITS-1:0] m_x;
  logic [COORD_BITS-1:0] m_y;
  logic [VAL_W-1:0]      m_value;
  logic                  m_first;

  assign points.ready   = (state == ST_LOAD);
  assign in_acc         = points.valid && points.ready;
  assign out_acc        = route.valid && route.ready;
  assign route.valid    = out_v;
  assign route.out_x    = out_x_r;
  assign route.out_y    = out_y_r;
  assign route.out_last = out_last_r;

  assign store_ok  = (count < CNT_MAX);
  assign count_inc = count + CNT_ONE;
  assign start_inc = start + CNT_ONE;
  assign last_pos  = count - CNT_ONE;
  assign issue     = (state == ST_SCAN) && (issue_j < count);
  assign m_first   = (m_idx == start[IDX_W-1:0]);

  // RAM write port: loading, then the two halves of each swap.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = {points.x, points.y};
    unique case (state)
      ST_LOAD: begin
        wr_en = in_acc && store_ok;
      end
      ST_SWAP_A: begin
        wr_en   = 1'b1;
        wr_addr = start[IDX_W-1:0];
        wr_data = best_pt;
      end
      ST_SWAP_B: begin
        wr_en   = 1'b1;
        wr_addr = best_idx;
        wr_data = first_pt;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign rd_addr = (state == ST_EMIT_RD) ? k[IDX_W-1:0] : issue_j[IDX_W-1:0];

  nnro_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  nnro_metric #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_metric (
    .clk       (clk),
    .rst       (rst),
    .mode      (seed ? MODE_SUM : MODE_DIST),
    .ref_x     (cur[PT_W-1:COORD_BITS]),
    .ref_y     (cur[COORD_BITS-1:0]),
    .in_valid  (rd_valid),
    .in_idx    (rd_idx),
    .in_x      (rd_data[PT_W-1:COORD_BITS]),
    .in_y      (rd_data[COORD_BITS-1:0]),
    .out_valid (m_valid),
    .out_idx   (m_idx),
    .out_x     (m_x),
    .out_y     (m_y),
    .out_value (m_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      start    <= '0;
      issue_j  <= '0;
      k        <= '0;
      seed     <= 1'b0;
      rd_valid <= 1'b0;
      out_v    <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        issue_j <= issue_j + CNT_ONE;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_acc) begin
            if (store_ok) begin
              count <= count_inc;
            end
            if (points.last) begin
              // Closing transaction: start the x+y seed pass at position 0.
              state   <= ST_SCAN;
              seed    <= 1'b1;
              start   <= '0;
              issue_j <= '0;
            end
          end
        end
        ST_SCAN: begin
          // The scan ends when the final index leaves the metric unit.
          if (m_valid && (m_idx == last_pos[IDX_W-1:0])) begin
            state <= ST_SWAP_A;
          end
        end
        ST_SWAP_A: begin
          state <= ST_SWAP_B;
        end
        ST_SWAP_B: begin
          seed  <= 1'b0;
          start <= start_inc;
          if (start_inc < count) begin
            state   <= ST_SCAN;
            issue_j <= start_inc;
          end else begin
            state <= ST_EMIT_RD;
            k     <= '0;
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          out_v <= 1'b1;
          state <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_acc) begin
            out_v <= 1'b0;
            if (out_last_r) begin
              count <= '0;
              state <= ST_LOAD;
            end else begin
              k     <= k + CNT_ONE;
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    rd_idx <= issue_j[IDX_W-1:0];
    if (m_valid) begin
      // Strict less-than keeps the earliest point on ties.
      if (m_first || (m_value < best_val)) begin
        best_val <= m_value;
        best_idx <= m_idx;
        best_pt  <= {m_x, m_y};
      end
      if (m_first) begin
        first_pt <= {m_x, m_y};
      end
    end
    if (state == ST_SWAP_B) begin
      cur <= best_pt;
    end
    if (state == ST_EMIT_LD) begin
      out_x_r    <= rd_data[PT_W-1:COORD_BITS];
      out_y_r    <= rd_data[COORD_BITS-1:0];
      out_last_r <= (k == last_pos);
    end
  end

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(points.ready && route.valid))
    else $error("input ready while a route transaction is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("point count beyond capacity");

  a_metric_in_set: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> ({1'b0, m_idx} < {1'b0, count}))
    else $error("metric result for an index outside the set");

  a_set_closes: assert property (@(posedge clk) disable iff (rst)
    (out_acc && route.out_last) |=> (count == '0 && points.ready))
    else $error("set not cleared after the final route transaction");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_RD) |-> (count != '0 && k < count))
    else $error("emit position outside the set");

endmodule

// ===== verif/tb_nearest_neighbor_route_order.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest-neighbor route order: block-level testbench
// Sends sets of camera points and checks that each route comes back in the
// greedy nearest-neighbor order, computed here from the accepted points.
// ----------------------------------------------------------------------------
module tb_nearest_neighbor_route_order;
  import nnro_pkg::*;

  localparam int MAX_POINTS = NNRO_MAX_POINTS;
  localparam int COORD_BITS = NNRO_COORD_BITS;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  // Roughly how many points the stimulus sends before it stops.
  localparam int TARGET_POINTS = 470;
  // Length of the one long stall on the route channel. It is longer than the
  // ordering of a full set, so the route backs up and the points channel stalls.
  localparam int ROUTE_HOLD_CYCLES = 600;
  // Cycles to watch for stray route transactions once nothing is expected.
  localparam int DRAIN_CYCLES = 50;
  // Hard stop for the whole run.
  localparam int RUN_LIMIT_NS = 3_000_000;

  // Idling pattern of the two channels. The pattern travels with each point,
  // so the route side follows the phase of the point last put on the channel.
  typedef enum logic [1:0] {
    PACE_ROUTE_SLOW,   // points idle chance 28 percent, route 68
    PACE_POINTS_SLOW,  // points idle chance 68 percent, route 28
    PACE_FULL          // neither side idles
  } pace_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
    pace_t                 pace;
    logic                  drain_first;  // wait for every route point first
    logic                  hold_route;   // start the long route stall
  } point_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } route_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nnro_in_if  #(.W(COORD_BITS)) points_ch ();
  nnro_out_if #(.W(COORD_BITS)) route_ch ();

  nearest_neighbor_route_order #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .points(points_ch),
    .route (route_ch)
  );

  // Points waiting to go out, and route points that the block still owes.
  point_item_t  pending_points[$];
  route_point_t route_expect[$];

  // Our own copy of the point store. Only the first held_count entries are
  // ever read, so the store needs no reset value.
  logic [COORD_BITS-1:0] held_x[MAX_POINTS];
  logic [COORD_BITS-1:0] held_y[MAX_POINTS];
  int held_count = 0;

  // Driver state shared with the route-side process through registers.
  pace_t route_pace  = PACE_ROUTE_SLOW;
  logic  stall_route = 1'b0;
  int    hold_left   = 0;

  // Filling state used while the stimulus is queued.
  pace_t fill_pace  = PACE_ROUTE_SLOW;
  logic  fill_drain = 1'b0;
  logic  fill_hold  = 1'b0;

  int points_queued   = 0;
  int points_accepted = 0;
  int points_dropped  = 0;
  int routes_ordered  = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int sets_queued     = 0;

  // --------------------------------------------------------------------------
  // Clock, reset and known values on every block input from time zero.
  // --------------------------------------------------------------------------
  initial begin
    points_ch.valid = 1'b0;
    points_ch.x     = '0;
    points_ch.y     = '0;
    points_ch.last  = 1'b0;
    route_ch.ready  = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Route predictor.
  // --------------------------------------------------------------------------
  function automatic void swap_held(int a, int b);
    logic [COORD_BITS-1:0] t;
    t = held_x[a]; held_x[a] = held_x[b]; held_x[b] = t;
    t = held_y[a]; held_y[a] = held_y[b]; held_y[b] = t;
  endfunction

  // Squared Euclidean distance between two held points, at full precision.
  function automatic logic [2*COORD_BITS:0] gap_squared(int a, int b);
    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [2*COORD_BITS-1:0] dx2;
    logic [2*COORD_BITS-1:0] dy2;
    dx  = (held_x[a] > held_x[b]) ? held_x[a] - held_x[b] : held_x[b] - held_x[a];
    dy  = (held_y[a] > held_y[b]) ? held_y[a] - held_y[b] : held_y[b] - held_y[a];
    dx2 = dx * dx;
    dy2 = dy * dy;
    return {1'b0, dx2} + {1'b0, dy2};
  endfunction

  // Greedy ordering in place: smallest x+y first, then always the nearest of
  // the points not yet placed. Strict less-than keeps the earliest on ties.
  function automatic void order_held(int n);
    logic [COORD_BITS:0]   best_sum;
    logic [COORD_BITS:0]   sum;
    logic [2*COORD_BITS:0] best_gap;
    logic [2*COORD_BITS:0] gap;
    int best;
    best     = 0;
    best_sum = {1'b0, held_x[0]} + {1'b0, held_y[0]};
    for (int j = 1; j < n; j++) begin
      sum = {1'b0, held_x[j]} + {1'b0, held_y[j]};
      if (sum < best_sum) begin
        best_sum = sum;
        best     = j;
      end
    end
    swap_held(0, best);
    for (int i = 0; i + 1 < n; i++) begin
      best     = i + 1;
      best_gap = gap_squared(i, best);
      for (int j = i + 2; j < n; j++) begin
        gap = gap_squared(i, j);
        if (gap < best_gap) begin
          best_gap = gap;
          best     = j;
        end
      end
      swap_held(i + 1, best);
    end
  endfunction

  // Called once per accepted point. A point that finds the store full is
  // dropped, but its last flag still closes the set.
  function automatic void predict_route(logic [COORD_BITS-1:0] x,
                                        logic [COORD_BITS-1:0] y,
                                        logic last);
    route_point_t rp;
    if (held_count < MAX_POINTS) begin
      held_x[held_count] = x;
      held_y[held_count] = y;
      held_count++;
    end else begin
      points_dropped++;
    end
    if (!last) return;
    order_held(held_count);
    for (int k = 0; k < held_count; k++) begin
      rp.x    = held_x[k];
      rp.y    = held_y[k];
      rp.last = (k == held_count - 1);
      route_expect.push_back(rp);
    end
    routes_ordered++;
    held_count = 0;
  endfunction

  function automatic int points_idle_pct(pace_t p);
    case (p)
      PACE_ROUTE_SLOW:  return 28;
      PACE_POINTS_SLOW: return 68;
      default:          return 0;
    endcase
  endfunction

  function automatic int route_idle_pct(pace_t p);
    case (p)
      PACE_ROUTE_SLOW:  return 68;
      PACE_POINTS_SLOW: return 28;
      default:          return 0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Points driver. A point stays on the channel until it is taken; only then
  // may the driver idle or move to the next one. Each accepted transaction
  // goes straight into the predictor, so the expected route is queued before
  // the block can start to emit it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    point_item_t nxt;
    logic        start_hold;
    start_hold = 1'b0;
    if (rst) begin
      points_ch.valid <= 1'b0;
      points_ch.x     <= '0;
      points_ch.y     <= '0;
      points_ch.last  <= 1'b0;
    end else begin
      if (points_ch.valid && points_ch.ready) begin
        predict_route(points_ch.x, points_ch.y, points_ch.last);
        points_accepted++;
      end
      if (!points_ch.valid || points_ch.ready) begin
        if (pending_points.size() == 0) begin
          points_ch.valid <= 1'b0;
        end else if (pending_points[0].drain_first && route_expect.size() != 0) begin
          // Pause until the block has handed back every point it owes.
          points_ch.valid <= 1'b0;
        end else if ($urandom_range(0, 99) < points_idle_pct(pending_points[0].pace)) begin
          points_ch.valid <= 1'b0;
        end else begin
          nxt = pending_points.pop_front();
          points_ch.valid <= 1'b1;
          points_ch.x     <= nxt.x;
          points_ch.y     <= nxt.y;
          points_ch.last  <= nxt.last;
          route_pace      <= nxt.pace;
          start_hold       = nxt.hold_route;
        end
      end
    end
    stall_route <= start_hold;
  end

  // --------------------------------------------------------------------------
  // Route-side ready. Normally random per the current pace; once, a long
  // stall counted here lets the block fill up while points keep coming.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      route_ch.ready <= 1'b0;
      hold_left      <= 0;
    end else if (stall_route) begin
      route_ch.ready <= 1'b0;
      hold_left      <= ROUTE_HOLD_CYCLES;
    end else if (hold_left != 0) begin
      route_ch.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else begin
      route_ch.ready <= ($urandom_range(0, 99) >= route_idle_pct(route_pace));
    end
  end

  // --------------------------------------------------------------------------
  // Route monitor: every transaction is checked against the oldest expected
  // route point, one field at a time.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] MISMATCH at route point %0d: %s", $time, results_checked, what);
  endtask

  always @(posedge clk) begin
    route_point_t want;
    if (!rst && route_ch.valid && route_ch.ready) begin
      if (route_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction x=%0d y=%0d last=%0b",
                                  route_ch.out_x, route_ch.out_y, route_ch.out_last));
      end else begin
        want = route_expect.pop_front();
        if (route_ch.out_x !== want.x)
          report_mismatch($sformatf("out_x got %0d, want %0d", route_ch.out_x, want.x));
        if (route_ch.out_y !== want.y)
          report_mismatch($sformatf("out_y got %0d, want %0d", route_ch.out_y, want.y));
        if (route_ch.out_last !== want.last)
          report_mismatch($sformatf("out_last got %0b, want %0b",
                                    route_ch.out_last, want.last));
      end
      results_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  task automatic queue_point(int x, int y, bit last);
    point_item_t it;
    it.x           = x[COORD_BITS-1:0];
    it.y           = y[COORD_BITS-1:0];
    it.last        = last;
    it.pace        = fill_pace;
    it.drain_first = fill_drain;
    it.hold_route  = fill_hold;
    pending_points.push_back(it);
    fill_drain = 1'b0;
    fill_hold  = 1'b0;
    points_queued++;
  endtask

  function automatic int pick_coord(bit clustered, int base);
    int r;
    r = $urandom_range(0, 99);
    if (clustered) return base + $urandom_range(0, 3);
    if (r < 6)     return 0;
    if (r < 12)    return COORD_MAX;
    return $urandom_range(0, COORD_MAX);
  endfunction

  // One random set. Most are normal sizes; a few overfill the store so that
  // points, always among them the closing one, are dropped. Clustered sets pack the
  // points into a tiny square to force equal distances and repeated points.
  task automatic queue_random_set(int n);
    bit clustered;
    int bx;
    int by;
    clustered = ($urandom_range(0, 99) < 25);
    bx = $urandom_range(0, COORD_MAX - 3);
    by = $urandom_range(0, COORD_MAX - 3);
    for (int k = 0; k < n; k++)
      queue_point(pick_coord(clustered, bx), pick_coord(clustered, by), k == n - 1);
    sets_queued++;
  endtask

  function automatic int random_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4);
    if (r < 20) return $urandom_range(1, 3);
    if (r < 35) return MAX_POINTS;
    return $urandom_range(2, MAX_POINTS);
  endfunction

  initial begin
    bit hold_done;
    hold_done = 1'b0;

    // Directed sets. A single point is its own route.
    queue_point(COORD_MAX, COORD_MAX, 1'b1);
    // Corners: (0,0) starts, and the two corners one edge away are equally
    // near, so the one stored first must come next.
    queue_point(COORD_MAX, COORD_MAX, 1'b0);
    queue_point(0, 0, 1'b0);
    queue_point(COORD_MAX, 0, 1'b0);
    queue_point(0, COORD_MAX, 1'b1);
    // All three share the same x+y; the first one stored must lead.
    queue_point(200, 10, 1'b0);
    queue_point(10, 200, 1'b0);
    queue_point(105, 105, 1'b1);
    // Repeated points: a distance of zero is a fair nearest choice.
    queue_point(50, 60, 1'b0);
    queue_point(50, 60, 1'b1);
    // One point too many, and it is the one that closes the set.
    fill_drain = 1'b1;
    for (int k = 0; k <= MAX_POINTS; k++)
      queue_point(k * 15, COORD_MAX - k * 13, k == MAX_POINTS);

    // Random sets, in three idling phases.
    while (points_queued < TARGET_POINTS) begin
      if (points_queued < TARGET_POINTS / 3)
        fill_pace = PACE_ROUTE_SLOW;
      else if (points_queued < 2 * TARGET_POINTS / 3)
        fill_pace = PACE_POINTS_SLOW;
      else
        fill_pace = PACE_FULL;
      if (sets_queued % 7 == 3)
        fill_drain = 1'b1;
      if (fill_pace == PACE_FULL && !hold_done) begin
        // Stall the route for a full set and keep offering the next one.
        fill_hold = 1'b1;
        hold_done = 1'b1;
        queue_random_set(MAX_POINTS);
      end else begin
        queue_random_set(random_set_size());
      end
    end

    // Wait until every point is taken and every route point has come back,
    // then keep watching for anything extra.
    while (pending_points.size() != 0 || points_ch.valid || route_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ordered %0d routes from %0d points (%0d dropped at a full store).",
             routes_ordered, points_accepted, points_dropped);
    $display("Checked %0d route points through three idling phases and one long stall.",
             results_checked);
    if (mismatches == 0 && route_expect.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d route points still expected.", route_expect.size());
    $display("status: fail");
    $finish;
  end

endmodule
